// ===== src/spe_pkg.sv =====
`default_nettype none
package spe_pkg;
    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_EXT  = 3'd1;
    localparam logic [2:0] PH_PAY  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;

    localparam logic [2:0] K_END = 3'd0;
    localparam logic [2:0] K_TS  = 3'd1;
    localparam logic [2:0] K_EVT = 3'd2;
    localparam logic [2:0] K_SRC = 3'd3;
    localparam logic [2:0] K_CTX = 3'd4;
    localparam logic [2:0] K_OP  = 3'd5;
    localparam logic [2:0] K_ADR = 3'd6;
    localparam logic [2:0] K_CNT = 3'd7;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_HDR   = 2'd1;
    localparam logic [1:0] E_CLASS = 2'd2;
    localparam logic [1:0] E_TRUNC = 2'd3;

    localparam logic [63:0] TOPFILL = 64'hFF00_0000_0000_0000;
    localparam logic [63:0] LOW56   = 64'h00FF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  sub;
        logic [63:0] value;
        logic [7:0]  attr;
        logic [18:0] flags;
        logic        last;
        logic [1:0]  err;
    } t_result;

    function automatic logic [18:0] op_flags(input logic [1:0] cls, input logic [7:0] p);
        logic [18:0] f;
        logic        atomic;
        logic [7:0]  m;
        f = '0;
        atomic = (p & 8'hE2) == 8'h02;
        m = p & 8'hFE;
        if (cls == 2'd0) begin
            f[0] = p[0];
            f[1] = (p & 8'h89) == 8'h08;
            f[2] = p[2];
        end else if (cls == 2'd1) begin
            f[0] = p[0];
            f[1] = !p[0];
            f[2] = m == 8'h00;
            f[3] = atomic;
            f[4] = atomic && p[2];
            f[5] = atomic && p[3];
            f[6] = atomic && p[4];
            f[7] = m == 8'h04;
            f[8] = (p & 8'h0A) == 8'h08;
            f[9] = m == 8'h10;
            f[10] = m == 8'h30;
            f[11] = m == 8'h12;
            f[12] = m == 8'h20;
            f[13] = p == 8'h25;
        end else begin
            f[0] = p[0];
            f[1] = m == 8'h02;
        end
        return f;
    endfunction
endpackage
`default_nettype wire

// ===== src/spe_trace_packet_decoder_unit.sv =====
// Trace packet decoder. Bytes of a trace buffer enter on the input channel
// (i_valid/o_ready, fields i_data_byte and i_last_byte); each completed packet
// gives one item on the output channel (o_valid/i_ready). Padding bytes, header
// bytes, skipped bytes and payload bytes other than the last produce no item,
// except that an unknown header gives an error item. After an error, bytes are
// dropped without any item up to and including the last byte of the buffer.
// Otherwise the last byte of a buffer always produces an item that closes the
// record.
// One byte is taken per cycle while o_ready is high. The parser state updates
// in the cycle of acceptance and the decoded item stands in the output
// register in the cycle after it.
// When the receiver stalls, the output register holds its item and o_ready is
// low until that item is taken; in the cycle in which it is taken a new byte
// is accepted again.
// The i_cross_endian_we write selects big-endian payloads and is to be made
// only while the block is idle, which the block does not enforce. Synchronous
// active-low reset clears parser, stream offset, halt, byte order, output valid.
`default_nettype none
module spe_trace_packet_decoder_unit
    import spe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cross_endian_we,
    input  wire logic        i_cross_endian,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_packet_kind,
    output logic [4:0]       o_sub_index,
    output logic [63:0]      o_value,
    output logic [7:0]       o_attr,
    output logic [18:0]      o_flags,
    output logic             o_record_last,
    output logic [1:0]       o_error
);
    logic        r_cross;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_hdr, n_hdr;
    logic [7:0]  r_ext, n_ext;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_left, n_left;
    logic [3:0]  r_len, n_len;
    logic [3:0]  r_off;
    logic [4:0]  r_skip, n_skip;
    logic        r_halt, n_halt;
    logic        r_ovalid;
    t_result     r_res, res, fin;
    logic        emit;
    logic        accept;

    logic        b_known;
    logic [3:0]  align, hoff, size;
    logic [4:0]  skipv;
    logic [2:0]  bi;
    logic [3:0]  left_m1;
    logic [4:0]  skip_m1;
    logic [7:0]  hh;
    logic [4:0]  idx;
    logic [1:0]  el;
    logic        ns;

    assign b_known = i_data_byte == 8'h71 || (i_data_byte & 8'hCF) == 8'h42 ||
                     (i_data_byte & 8'hCF) == 8'h43 || (i_data_byte & 8'hFC) == 8'h64 ||
                     (i_data_byte & 8'hFC) == 8'h48 || (i_data_byte & 8'hF8) == 8'hB0 ||
                     (i_data_byte & 8'hF8) == 8'h98;
    assign align = 4'd2 << r_hdr[1:0];
    assign hoff = r_off - 4'd1;
    assign size = align - (hoff & (align - 4'd1));
    assign skipv = (r_hdr[1:0] == 2'd3 && size == 4'd0) ? 5'd14 :
                   (size >= 4'd2) ? {1'b0, size - 4'd2} : 5'd0;
    assign bi = 3'(r_len - r_left);
    assign left_m1 = r_left - 4'd1;
    assign skip_m1 = r_skip - 5'd1;

    // Decode of the packet completed by this byte, from the updated payload.
    always_comb begin
        fin = '0;
        hh = (r_ext != 8'd0) ? r_ext : r_hdr;
        idx = (r_ext != 8'd0) ? {r_hdr[1:0], r_ext[2:0]} : {2'b00, r_hdr[2:0]};
        el = n_acc[62:61];
        ns = n_acc[63];
        fin.kind = K_ADR;
        fin.sub = idx;
        fin.value = n_acc;
        if (r_ext == 8'd0 && r_hdr == 8'h71) begin
            fin.kind = K_TS;
            fin.sub = '0;
            fin.last = 1'b1;
        end else if (r_ext == 8'd0 && (r_hdr & 8'hCF) == 8'h42) begin
            fin.kind = K_EVT;
            fin.sub = '0;
            fin.value = '0;
            fin.flags = n_acc[18:0] & 19'h60FFF;
        end else if (r_ext == 8'd0 && (r_hdr & 8'hCF) == 8'h43) begin
            fin.kind = K_SRC;
            fin.sub = '0;
        end else if (r_ext == 8'd0 && (r_hdr & 8'hFC) == 8'h64) begin
            fin.kind = K_CTX;
            fin.sub = {3'b000, r_hdr[1:0]};
        end else if (r_ext == 8'd0 && (r_hdr & 8'hFC) == 8'h48) begin
            fin.value = '0;
            if (r_hdr[1:0] == 2'd3) begin
                fin.kind = K_END;
                fin.sub = '0;
                fin.last = 1'b1;
                fin.err = E_CLASS;
            end else begin
                fin.kind = K_OP;
                fin.sub = {3'b000, r_hdr[1:0]};
                fin.flags = op_flags(r_hdr[1:0], n_acc[7:0]);
            end
        end else if ((hh & 8'hF8) == 8'h98) begin
            fin.kind = K_CNT;
        end else if (idx == 5'd0 || idx == 5'd1 || idx == 5'd4) begin
            fin.value = (ns && (el == 2'd1 || el == 2'd2)) ? (n_acc | TOPFILL)
                                                           : (n_acc & LOW56);
            fin.attr = {5'd0, ns, el};
        end else if (idx == 5'd2) begin
            fin.value = (n_acc[55:52] == 4'hF) ? (n_acc | TOPFILL) : (n_acc & LOW56);
            fin.attr = n_acc[63:56];
        end else if (idx == 5'd3) begin
            fin.value = n_acc & LOW56;
            fin.attr = {2'b00, n_acc[63], n_acc[62], n_acc[59:56]};
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr = r_hdr;
        n_ext = r_ext;
        n_acc = r_acc;
        n_left = r_left;
        n_len = r_len;
        n_skip = r_skip;
        n_halt = r_halt;
        res = '0;
        res.last = 1'b1;
        emit = 1'b0;
        if (!r_halt) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (i_data_byte == 8'h00) begin
                        emit = 1'b0;
                    end else if (i_data_byte == 8'h01) begin
                        emit = 1'b1;
                    end else if (b_known) begin
                        n_hdr = i_data_byte;
                        n_ext = '0;
                        n_len = 4'd1 << i_data_byte[5:4];
                        n_left = 4'd1 << i_data_byte[5:4];
                        n_acc = '0;
                        n_phase = PH_PAY;
                        if (i_last_byte) begin
                            emit = 1'b1;
                            res.err = E_TRUNC;
                        end
                    end else if ((i_data_byte & 8'hFC) == 8'h20) begin
                        n_hdr = i_data_byte;
                        n_ext = '0;
                        n_phase = PH_EXT;
                        if (i_last_byte) begin
                            emit = 1'b1;
                            res.err = E_TRUNC;
                        end
                    end else begin
                        emit = 1'b1;
                        res.err = E_HDR;
                        n_halt = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_ext = i_data_byte;
                    if (i_data_byte == 8'h00) begin
                        n_skip = skipv;
                        n_phase = (skipv != 5'd0) ? PH_SKIP : PH_HDR;
                        if (i_last_byte && skipv != 5'd0) begin
                            emit = 1'b1;
                            res.err = E_TRUNC;
                        end
                    end else if ((i_data_byte & 8'hF8) == 8'hB0 ||
                                 (i_data_byte & 8'hF8) == 8'h98) begin
                        n_len = 4'd1 << i_data_byte[5:4];
                        n_left = 4'd1 << i_data_byte[5:4];
                        n_acc = '0;
                        n_phase = PH_PAY;
                        if (i_last_byte) begin
                            emit = 1'b1;
                            res.err = E_TRUNC;
                        end
                    end else begin
                        emit = 1'b1;
                        res.err = E_HDR;
                        n_halt = 1'b1;
                        n_phase = PH_HDR;
                    end
                end
                PH_PAY: begin
                    if (r_cross) begin
                        n_acc = {r_acc[55:0], i_data_byte};
                    end else begin
                        n_acc = r_acc | ({56'd0, i_data_byte} << {bi, 3'b000});
                    end
                    n_left = left_m1;
                    if (left_m1 == 4'd0) begin
                        n_phase = PH_HDR;
                        emit = 1'b1;
                        res = fin;
                        if (fin.err != E_NONE) n_halt = 1'b1;
                    end else if (i_last_byte) begin
                        emit = 1'b1;
                        res.err = E_TRUNC;
                    end
                end
                default: begin
                    n_skip = skip_m1;
                    if (skip_m1 == 5'd0) begin
                        n_phase = PH_HDR;
                    end else if (i_last_byte) begin
                        emit = 1'b1;
                        res.err = E_TRUNC;
                    end
                end
            endcase
            if (i_last_byte) begin
                emit = 1'b1;
                res.last = 1'b1;
            end else if (emit && !(res.err != E_NONE || res.last)) begin
                res.last = 1'b0;
            end
        end
    end

    assign o_ready = !r_ovalid || i_ready;
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross <= 1'b0;
            r_phase <= PH_HDR;
            r_hdr <= '0;
            r_ext <= '0;
            r_acc <= '0;
            r_left <= '0;
            r_len <= '0;
            r_off <= '0;
            r_skip <= '0;
            r_halt <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cross_endian_we) r_cross <= i_cross_endian;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (accept) begin
                if (i_last_byte) begin
                    r_phase <= PH_HDR;
                    r_hdr <= '0;
                    r_ext <= '0;
                    r_acc <= '0;
                    r_left <= '0;
                    r_len <= '0;
                    r_off <= '0;
                    r_skip <= '0;
                    r_halt <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_hdr <= n_hdr;
                    r_ext <= n_ext;
                    r_acc <= n_acc;
                    r_left <= n_left;
                    r_len <= n_len;
                    r_off <= r_off + 4'd1;
                    r_skip <= n_skip;
                    r_halt <= n_halt;
                end
                if (emit) r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) r_res <= res;
    end

    assign o_valid = r_ovalid;
    assign o_packet_kind = r_res.kind;
    assign o_sub_index = r_res.sub;
    assign o_value = r_res.value;
    assign o_attr = r_res.attr;
    assign o_flags = r_res.flags;
    assign o_record_last = r_res.last;
    assign o_error = r_res.err;
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import spe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_big;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  out_kind;
    logic [4:0]  out_sub;
    logic [63:0] out_value;
    logic [7:0]  out_attr;
    logic [18:0] out_flags;
    logic        out_last;
    logic [1:0]  out_err;

    spe_trace_packet_decoder_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cross_endian_we(cfg_we), .i_cross_endian(cfg_big),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(in_byte), .i_last_byte(in_last),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_packet_kind(out_kind), .o_sub_index(out_sub), .o_value(out_value),
        .o_attr(out_attr), .o_flags(out_flags), .o_record_last(out_last),
        .o_error(out_err)
    );

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    t_byte_item pending_bytes[$];
    t_result    expected_packets[$];
    int         fail_count;
    int         checked_count;
    int         bytes_sent;
    bit         hold_input;

    // Predictor state.
    logic        big_endian;
    logic [2:0]  ph;
    logic [7:0]  hdr;
    logic [7:0]  ext;
    logic [63:0] acc;
    logic [3:0]  left;
    logic [3:0]  plen;
    logic [3:0]  offs;
    logic [4:0]  skip;
    logic        halt;

    function automatic t_result mk(logic [2:0] k, logic [4:0] s, logic [63:0] v,
                                   logic [7:0] a, logic [18:0] f, logic l,
                                   logic [1:0] e);
        t_result r;
        r.kind = k; r.sub = s; r.value = v; r.attr = a;
        r.flags = f; r.last = l; r.err = e;
        return r;
    endfunction

    function automatic logic [18:0] decode_op_flags(logic [1:0] cls, logic [7:0] p);
        logic [18:0] f;
        logic        atom;
        logic [7:0]  m;
        f = '0;
        m = p & 8'hFE;
        atom = (p & 8'hE2) == 8'h02;
        if (cls == 2'd0) begin
            f[0] = p[0]; f[1] = (p & 8'h89) == 8'h08; f[2] = p[2];
        end else if (cls == 2'd1) begin
            f[0] = p[0]; f[1] = ~p[0]; f[2] = m == 8'h00; f[3] = atom;
            f[4] = atom & p[2]; f[5] = atom & p[3]; f[6] = atom & p[4];
            f[7] = m == 8'h04; f[8] = (p & 8'h0A) == 8'h08;
            f[9] = m == 8'h10; f[10] = m == 8'h30; f[11] = m == 8'h12;
            f[12] = m == 8'h20; f[13] = p == 8'h25;
        end else begin
            f[0] = p[0]; f[1] = m == 8'h02;
        end
        return f;
    endfunction

    task automatic parser_restart();
        ph = PH_HDR; hdr = 0; ext = 0; acc = 0; left = 0; plen = 0;
        offs = 0; skip = 0; halt = 0;
    endtask

    task automatic start_payload(logic [7:0] h);
        plen = 4'd1 << h[5:4];
        left = plen;
        acc = 0;
        ph = PH_PAY;
    endtask

    task automatic complete_packet(output t_result r);
        logic [7:0]  h;
        logic [4:0]  idx;
        logic [1:0]  el;
        logic        ns;
        h = hdr;
        ph = PH_HDR;
        if (ext == 0 && h == 8'h71) r = mk(K_TS, 0, acc, 0, 0, 1, E_NONE);
        else if (ext == 0 && (h & 8'hCF) == 8'h42)
            r = mk(K_EVT, 0, 0, 0, acc[18:0] & 19'h60FFF, 0, E_NONE);
        else if (ext == 0 && (h & 8'hCF) == 8'h43) r = mk(K_SRC, 0, acc, 0, 0, 0, E_NONE);
        else if (ext == 0 && (h & 8'hFC) == 8'h64)
            r = mk(K_CTX, {3'b0, h[1:0]}, acc, 0, 0, 0, E_NONE);
        else if (ext == 0 && (h & 8'hFC) == 8'h48) begin
            if (h[1:0] == 2'd3) begin
                halt = 1;
                r = mk(K_END, 0, 0, 0, 0, 1, E_CLASS);
            end else begin
                r = mk(K_OP, {3'b0, h[1:0]}, 0, 0, decode_op_flags(h[1:0], acc[7:0]),
                       0, E_NONE);
            end
        end else begin
            if (ext != 0) begin
                idx = {h[1:0], ext[2:0]};
                h = ext;
            end else begin
                idx = {2'b0, h[2:0]};
            end
            el = acc[62:61];
            ns = acc[63];
            if ((h & 8'hF8) == 8'h98) r = mk(K_CNT, idx, acc, 0, 0, 0, E_NONE);
            else if (idx == 0 || idx == 1 || idx == 4)
                r = mk(K_ADR, idx, (ns && (el == 1 || el == 2)) ? (acc | TOPFILL)
                       : (acc & LOW56), {5'b0, ns, el}, 0, 0, E_NONE);
            else if (idx == 2)
                r = mk(K_ADR, idx, (acc[55:52] == 4'hF) ? (acc | TOPFILL)
                       : (acc & LOW56), acc[63:56], 0, 0, E_NONE);
            else if (idx == 3)
                r = mk(K_ADR, idx, acc & LOW56, {2'b0, acc[63], acc[62], acc[59:56]},
                       0, 0, E_NONE);
            else r = mk(K_ADR, idx, acc, 0, 0, 0, E_NONE);
        end
    endtask

    task automatic predict_byte(t_byte_item it);
        t_result    r;
        bit         got;
        logic [7:0] b;
        logic [3:0] off;
        logic [3:0] hoff;
        logic [4:0] align;
        logic [4:0] size;
        logic [4:0] sk;
        logic [2:0] bidx;
        b = it.data;
        got = 0;
        off = offs;
        offs = off + 4'd1;
        if (halt) begin
            if (it.last) parser_restart();
            return;
        end
        case (ph)
            PH_HDR: begin
                if (b == 8'h00) begin
                    got = 0;
                end else if (b == 8'h01) begin
                    r = mk(K_END, 0, 0, 0, 0, 1, E_NONE); got = 1;
                end else if (b == 8'h71 || (b & 8'hCF) == 8'h42 || (b & 8'hCF) == 8'h43 ||
                             (b & 8'hFC) == 8'h64 || (b & 8'hFC) == 8'h48 ||
                             (b & 8'hF8) == 8'hB0 || (b & 8'hF8) == 8'h98) begin
                    hdr = b; ext = 0; start_payload(b);
                    if (it.last) begin
                        halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                    end
                end else if ((b & 8'hFC) == 8'h20) begin
                    hdr = b; ext = 0; ph = PH_EXT;
                    if (it.last) begin
                        halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                    end
                end else begin
                    halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_HDR); got = 1;
                end
            end
            PH_EXT: begin
                ext = b;
                if (b == 0) begin
                    align = 5'd2 << hdr[1:0];
                    hoff = off - 4'd1;
                    size = align - ({1'b0, hoff} & (align - 5'd1));
                    sk = (size >= 5'd2) ? size - 5'd2 : 5'd0;
                    skip = sk;
                    ph = (sk != 0) ? PH_SKIP : PH_HDR;
                    if (it.last && sk != 0) begin
                        halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                    end
                end else if ((b & 8'hF8) == 8'hB0 || (b & 8'hF8) == 8'h98) begin
                    start_payload(b);
                    if (it.last) begin
                        halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                    end
                end else begin
                    halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_HDR); got = 1;
                end
            end
            PH_PAY: begin
                bidx = 3'(plen - left);
                if (big_endian) acc = {acc[55:0], b};
                else acc = acc | ({56'b0, b} << {bidx, 3'b000});
                left = left - 4'd1;
                if (left == 0) begin
                    complete_packet(r); got = 1;
                end else if (it.last) begin
                    halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                end
            end
            default: begin
                skip = skip - 5'd1;
                if (skip == 0) ph = PH_HDR;
                else if (it.last) begin
                    halt = 1; ph = PH_HDR; r = mk(K_END, 0, 0, 0, 0, 1, E_TRUNC); got = 1;
                end
            end
        endcase
        if (it.last) begin
            if (!got) begin
                r = mk(K_END, 0, 0, 0, 0, 1, E_NONE); got = 1;
            end else begin
                r.last = 1;
            end
            parser_restart();
        end
        if (got) expected_packets.push_back(r);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Input driver.
    int in_gap;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_byte <= 0;
            in_last <= 0;
            in_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_byte({in_byte, in_last});
                bytes_sent++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0 || hold_input || pending_bytes.size() == 0) begin
                    in_valid <= 0;
                    if (in_gap > 0) in_gap--;
                end else begin
                    t_byte_item nx;
                    nx = pending_bytes.pop_front();
                    in_valid <= 1;
                    in_byte <= nx.data;
                    in_last <= nx.last;
                    in_gap = gap_len();
                end
            end
        end
    end

    // Output monitor.
    int out_gap;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 0;
            out_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_packets.size() == 0) begin
                    $error("unexpected item kind=%0d", out_kind);
                    fail_count++;
                end else begin
                    t_result e;
                    e = expected_packets.pop_front();
                    checked_count++;
                    if (out_kind !== e.kind) begin
                        $error("packet_kind exp %0h got %0h", e.kind, out_kind); fail_count++;
                    end
                    if (out_sub !== e.sub) begin
                        $error("sub_index exp %0h got %0h", e.sub, out_sub); fail_count++;
                    end
                    if (out_value !== e.value) begin
                        $error("value exp %0h got %0h", e.value, out_value); fail_count++;
                    end
                    if (out_attr !== e.attr) begin
                        $error("attr exp %0h got %0h", e.attr, out_attr); fail_count++;
                    end
                    if (out_flags !== e.flags) begin
                        $error("flags exp %0h got %0h", e.flags, out_flags); fail_count++;
                    end
                    if (out_last !== e.last) begin
                        $error("record_last exp %0h got %0h", e.last, out_last);
                        fail_count++;
                    end
                    if (out_err !== e.err) begin
                        $error("error exp %0h got %0h", e.err, out_err); fail_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_ready <= 0;
                out_gap--;
            end else begin
                out_ready <= 1;
                out_gap = gap_len();
            end
        end
    end

    task automatic add_byte(logic [7:0] d, logic l);
        t_byte_item it;
        it.data = d;
        it.last = l;
        pending_bytes.push_back(it);
    endtask

    task automatic add_packet(logic [7:0] h, logic end_buf);
        int n;
        add_byte(h, 0);
        n = 1 << h[5:4];
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), end_buf && i == n - 1);
    endtask

    task automatic add_random_packet(logic end_buf);
        logic [7:0] h;
        int         sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0: h = 8'h71;
            1: h = 8'h42 | 8'($urandom_range(0, 3) << 4);
            2: h = 8'h43 | 8'($urandom_range(0, 3) << 4);
            3: h = 8'h64 | 8'($urandom_range(0, 3));
            4: h = 8'h48 | 8'($urandom_range(0, 3));
            5: h = 8'hB0 | 8'($urandom_range(0, 7));
            6: h = 8'h98 | 8'($urandom_range(0, 7));
            7: begin
                add_byte(8'h20 | 8'($urandom_range(0, 3)), 0);
                h = (($urandom_range(0, 1) != 0) ? 8'hB0 : 8'h98) | 8'($urandom_range(0, 7));
            end
            8: begin
                add_byte(8'h20 | 8'($urandom_range(0, 3)), 0);
                add_byte(8'h00, end_buf);
                return;
            end
            9: begin
                add_byte(8'h00, end_buf);
                return;
            end
            10: begin
                add_byte(8'h01, end_buf);
                return;
            end
            default: begin
                add_byte(8'($urandom_range(0, 255)), end_buf);
                return;
            end
        endcase
        add_byte(h, 0);
        for (int i = 0; i < (1 << h[5:4]); i++) begin
            if (end_buf == 0 && $urandom_range(0, 40) == 0) begin
                add_byte(8'($urandom_range(0, 255)), 1);
                return;
            end
            add_byte(8'($urandom_range(0, 255)), end_buf && i == (1 << h[5:4]) - 1);
        end
    endtask

    task automatic drain_and_wait();
        while (pending_bytes.size() != 0) @(posedge clk);
        @(posedge clk);
        while (in_valid || expected_packets.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_endian(logic v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_big <= v;
        big_endian = v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_big = 0;
        in_valid = 0;
        in_byte = 0;
        in_last = 0;
        out_ready = 0;
        hold_input = 0;
        fail_count = 0;
        checked_count = 0;
        bytes_sent = 0;
        big_endian = 0;
        parser_restart();
        repeat (11) @(posedge clk);
        rst_n <= 1;

        add_packet(8'h71, 0);
        add_packet(8'h72, 0);
        add_packet(8'h43, 0);
        add_packet(8'h67, 0);
        add_packet(8'h49, 0);
        add_packet(8'h4A, 0);
        add_packet(8'hB0, 0);
        add_packet(8'hB3, 0);
        add_packet(8'h98, 0);
        add_byte(8'h23, 0);
        add_packet(8'hBF, 0);
        add_byte(8'h00, 0);
        add_byte(8'h22, 0);
        add_byte(8'h00, 0);
        add_byte(8'h01, 1);
        add_byte(8'h4B, 0);
        add_byte(8'hFF, 0);
        add_byte(8'h55, 1);
        add_byte(8'h71, 0);
        add_byte(8'h12, 1);
        add_byte(8'hFF, 1);
        drain_and_wait();

        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            write_endian(phase_no[0] ^ 1'b1);
            for (int k = 0; k < 60; k++) begin
                add_random_packet($urandom_range(0, 9) == 0);
                if (k == 30 && phase_no == 1) begin
                    while (pending_bytes.size() != 0) @(posedge clk);
                    hold_input = 1;
                    while (in_valid || expected_packets.size() != 0) @(posedge clk);
                    hold_input = 0;
                end
            end
            add_byte(8'($urandom_range(0, 255)), 1);
            drain_and_wait();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d bytes in both byte orders and %0d decoded items.",
                 bytes_sent, checked_count);
        if (fail_count == 0 && expected_packets.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
